FILE: rtl/spd_pkg.sv
`default_nettype none

package spd_pkg;

    // Micro-PC step addresses
    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_PASS  = 3'd2;
    localparam logic [2:0] ST_PRIME = 3'd3;
    localparam logic [2:0] ST_LOOP  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_CHECK = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    // Sample and sum widths
    localparam int VW = 48;
    localparam int SAMPLE_W = 32;
    localparam int THR_W = 32;
    localparam int DEG_OUT_W = 6;
    localparam logic [THR_W-1:0] THR_RESET = 32'd66;

    // Datapath operation selected by a control word
    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_INIT  = 3'd1,
        OP_PASS  = 3'd2,
        OP_PRIME = 3'd3,
        OP_LOOP  = 3'd4,
        OP_NOP   = 3'd5,
        OP_CHECK = 3'd6,
        OP_EMIT  = 3'd7
    } t_op;

    // Branch condition: true goes to target, false to alt
    typedef enum logic [2:0] {
        CD_ALWAYS  = 3'd0,
        CD_LAST    = 3'd1,
        CD_NLT2    = 3'd2,
        CD_IDXEND  = 3'd3,
        CD_DONE    = 3'd4,
        CD_OUTFREE = 3'd5
    } t_cond;

    typedef struct packed {
        t_op        op;
        t_cond      cond;
        logic [2:0] target;
        logic [2:0] alt;
    } t_uword;

    // Control store
    function automatic t_uword ucode(input logic [2:0] step);
        t_uword w;
        case (step)
            ST_LOAD:  w = '{OP_LOAD,  CD_LAST,    ST_INIT,  ST_LOAD};
            ST_INIT:  w = '{OP_INIT,  CD_NLT2,    ST_EMIT,  ST_PASS};
            ST_PASS:  w = '{OP_PASS,  CD_ALWAYS,  ST_PRIME, ST_PRIME};
            ST_PRIME: w = '{OP_PRIME, CD_ALWAYS,  ST_LOOP,  ST_LOOP};
            ST_LOOP:  w = '{OP_LOOP,  CD_IDXEND,  ST_DRAIN, ST_LOOP};
            ST_DRAIN: w = '{OP_NOP,   CD_ALWAYS,  ST_CHECK, ST_CHECK};
            ST_CHECK: w = '{OP_CHECK, CD_DONE,    ST_EMIT,  ST_PASS};
            ST_EMIT:  w = '{OP_EMIT,  CD_OUTFREE, ST_LOAD,  ST_EMIT};
            default:  w = '{OP_NOP,   CD_ALWAYS,  ST_LOAD,  ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/series_polynomial_degree.sv
// Estimates the polynomial degree of a series of signed Q16.16 samples by
// repeated finite differences. Samples stream in one per cycle until tlast;
// samples beyond MAX_SAMPLES are dropped and the result is flagged in tuser.
// After tlast the input is held off while the store is differenced in place:
// a setup step, then a pass over the n stored values for each difference
// order (the store has one read port, so the pass walks it one entry a
// cycle), then a step to load the result register, which waits while an
// earlier result is still held there and not taken. The result register
// lets the next series start loading while the result waits.
// flat_threshold is to be written through the cfg channel only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module series_polynomial_degree
    import spd_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Sample stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,  // [31:0] sample
    input  wire logic        i_s_tlast,  // last_sample
    // Result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata,  // [5:0] degree, [53:6] deviation, [55:54] zero
    output logic             o_m_tuser,  // [0] truncated
    // flat_threshold write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int DW = (AW < 1) ? 1 : AW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);
    localparam logic [CW-1:0] CNT_TWO = CW'(2);

    // Store
    logic signed [VW-1:0] mem [MAX_SAMPLES];
    logic signed [VW-1:0] r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic signed [VW-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;

    // Sequencer and datapath registers
    logic [2:0]           r_pc, n_pc;
    logic [CW-1:0]        r_count;
    logic                 r_ovf;
    logic [AW-1:0]        r_idx;
    logic signed [VW-1:0] r_held;
    logic signed [VW-1:0] r_diff;
    logic                 r_acc_vld;
    logic [VW-1:0]        r_sum;
    logic [VW-1:0]        r_prev;
    logic [VW-1:0]        r_dev;
    logic [DW-1:0]        r_deg;
    logic [THR_W-1:0]     r_thr;
    logic                 r_m_valid;
    logic [DEG_OUT_W-1:0] r_m_deg;
    logic [VW-1:0]        r_m_dev;
    logic                 r_m_trunc;

    t_uword               uw;
    logic                 s_xfer;
    logic                 out_free;
    logic                 cond_true;
    logic                 idx_end;
    logic                 stop_flat;
    logic                 stop_rise;
    logic                 done;
    logic signed [VW:0]   diff_w;
    logic signed [VW-1:0] diff_sat;
    logic                 abs_neg;
    logic [VW:0]          acc_w;
    logic [31:0]          deg32;
    logic [DEG_OUT_W-1:0] deg_out;

    assign uw          = ucode(r_pc);
    assign o_s_tready  = (uw.op == OP_LOAD);
    assign s_xfer      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_m_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    // Pass bookkeeping
    assign idx_end   = ((CW'(r_idx) + CW'(1)) == r_count);
    assign stop_flat = (r_sum < VW'(r_thr));
    assign stop_rise = (r_deg != '0) && (r_sum > r_prev);
    assign done      = stop_flat || stop_rise || (r_count == CNT_TWO);

    // Saturating difference of neighboring entries
    assign diff_w   = {r_rdata[VW-1], r_rdata} - {r_held[VW-1], r_held};
    assign diff_sat = (diff_w[VW] != diff_w[VW-1])
                    ? (diff_w[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                    : diff_w[VW-1:0];

    // Absolute value folded into the accumulate add as invert plus carry-in
    assign abs_neg = r_diff[VW-1];
    assign acc_w   = {1'b0, r_sum} + {1'b0, (r_diff ^ {VW{abs_neg}})} + (VW+1)'(abs_neg);

    // Degree clamp to the field width
    assign deg32   = 32'(r_deg);
    assign deg_out = (deg32 > 32'd63) ? 6'd63 : deg32[DEG_OUT_W-1:0];

    // Branch evaluation
    always_comb begin
        case (uw.cond)
            CD_ALWAYS:  cond_true = 1'b1;
            CD_LAST:    cond_true = s_xfer && i_s_tlast;
            CD_NLT2:    cond_true = (r_count < CNT_TWO);
            CD_IDXEND:  cond_true = idx_end;
            CD_DONE:    cond_true = done;
            CD_OUTFREE: cond_true = out_free;
            default:    cond_true = 1'b1;
        endcase
        n_pc = cond_true ? uw.target : uw.alt;
    end

    // Store port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = VW'(signed'(i_s_tdata));
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (uw.op)
            OP_LOAD: begin
                mem_we = s_xfer && (r_count < CNT_MAX);
            end
            OP_PASS: begin
                mem_re = 1'b1;
            end
            OP_PRIME: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(1);
            end
            OP_LOOP: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx - AW'(1);
                mem_wdata = diff_sat;
                mem_re    = !idx_end;
                mem_raddr = r_idx + AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= ST_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_acc_vld <= 1'b0;
            r_m_valid <= 1'b0;
            r_thr     <= THR_RESET;
        end else begin
            r_pc      <= n_pc;
            r_acc_vld <= (uw.op == OP_LOOP);
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            // Result register: a new result replaces one leaving this cycle
            if ((uw.op == OP_EMIT) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (uw.op)
                OP_LOAD: begin
                    if (s_xfer) begin
                        if (r_count < CNT_MAX) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                OP_CHECK: begin
                    if (!(stop_flat || stop_rise)) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                OP_EMIT: begin
                    if (out_free) begin
                        r_count   <= '0;
                        r_ovf     <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_acc_vld) begin
            r_sum <= acc_w[VW] ? {VW{1'b1}} : acc_w[VW-1:0];
        end
        case (uw.op)
            OP_INIT: begin
                r_deg  <= '0;
                r_prev <= '0;
                r_dev  <= '0;
            end
            OP_PASS: begin
                r_sum <= '0;
            end
            OP_PRIME: begin
                r_held <= r_rdata;
                r_idx  <= AW'(1);
            end
            OP_LOOP: begin
                r_diff <= diff_sat;
                r_held <= r_rdata;
                if (!idx_end) begin
                    r_idx <= r_idx + AW'(1);
                end
            end
            OP_CHECK: begin
                r_dev  <= r_prev;
                r_prev <= r_sum;
                if (stop_flat) begin
                    r_deg <= r_deg;
                end else if (stop_rise) begin
                    r_deg <= r_deg - DW'(1);
                end else begin
                    r_deg <= r_deg + DW'(1);
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    r_m_deg   <= deg_out;
                    r_m_dev   <= r_dev;
                    r_m_trunc <= r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_m_dev, r_m_deg};
    assign o_m_tuser  = r_m_trunc;

    // Fill level never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("stored count above store depth");

    // Walk index stays inside the live part of the store
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_LOOP) |-> (CW'(r_idx) < r_count))
        else $error("difference walk beyond stored entries");

    // Saturating accumulation never goes down
    a_sum_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_vld |=> (r_sum >= $past(r_sum)))
        else $error("absolute sum decreased");

    // A finished series lands in the result register and loading resumes
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((uw.op == OP_EMIT) && out_free) |=> (o_m_tvalid && (r_pc == ST_LOAD)))
        else $error("result not posted after emit");

endmodule

`default_nettype wire
